/* src/lpp_pkg.sv */
// shared constants and types of the lidar point projector
`default_nettype none
package lpp_pkg;

   localparam int COEF_W     = 32;
   localparam int COORD_W    = 16;
   localparam int PROD_W     = COEF_W + COORD_W;
   localparam int BIAS_W     = COEF_W + 8;
   localparam int ROW_W      = PROD_W + 2;
   localparam int QUO_W      = 17;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int COL_NUM_W  = 24;
   localparam int COL_DEN_W  = 16;

   localparam logic [63:0] CROP_RESET = 64'h028F_FE9A_0600_1900;
   localparam logic [15:0] FULL_RESET = 16'd5120;

   typedef enum logic [2:0] {
      REG_COEF_M00_M01 = 3'd0,
      REG_COEF_M02_M03 = 3'd1,
      REG_COEF_M10_M11 = 3'd2,
      REG_COEF_M12_M13 = 3'd3,
      REG_COEF_M20_M21 = 3'd4,
      REG_COEF_M22_M23 = 3'd5,
      REG_CROP_LIMITS  = 3'd6,
      REG_FULL_DIST    = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic valid;
      logic behind;
      logic neg_a;
      logic neg_b;
   } side_type;

endpackage
`default_nettype wire

/* src/lpp_if.sv */
// request and response channel interfaces
`default_nettype none
interface lpp_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] point_x;
   logic signed [15:0] point_y;
   logic signed [15:0] point_z;
   logic        [15:0] reflectance;
   modport source (output valid, point_x, point_y, point_z, reflectance, input ready);
   modport sink   (input valid, point_x, point_y, point_z, reflectance, output ready);
endinterface

interface lpp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] pixel_u;
   logic signed [15:0] pixel_v;
   logic               behind_camera;
   logic        [7:0]  red_level;
   logic        [7:0]  green_level;
   modport source (output valid, pixel_u, pixel_v, behind_camera, red_level, green_level,
                   input ready);
   modport sink   (input valid, pixel_u, pixel_v, behind_camera, red_level, green_level,
                   output ready);
endinterface
`default_nettype wire

/* src/lidar_point_projector_core.sv */
// top level of the lidar point projector: crop, 3x4 projection, divide, colour
//
//  channel | direction | handshake            | payload
//  req     | in        | valid/ready          | point_x, point_y, point_z, reflectance
//  rsp     | out       | valid/ready          | pixel_u, pixel_v, behind_camera, red, green
//  csr     | in        | apb, pready tied hi  | eight registers at 8*i, 64-bit data
//
// one request per cycle while no response waits; a kept point passes the capture,
// product, row-sum and flag stages, 17 one-bit divider stages and output register
// cropped points leave a bubble and produce no response
// synchronous active-high reset clears valid bits and registers to defaults
// the whole pipeline holds while a response waits; req.ready = !rsp.valid | rsp.ready
`default_nettype none
module lidar_point_projector_core
   import lpp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   lpp_req_if.sink                    req,
   lpp_rsp_if.source                  rsp,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   // ---------------- configuration registers ----------------
   logic [63:0]   coef_ff [6];
   logic [63:0]   crop_ff;
   logic [15:0]   full_ff;
   reg_index_type csr_index;
   logic          csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1:3]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) coef_ff[i] <= '0;
         crop_ff <= CROP_RESET;
         full_ff <= FULL_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_COEF_M00_M01: coef_ff[0] <= csr_pwdata;
            REG_COEF_M02_M03: coef_ff[1] <= csr_pwdata;
            REG_COEF_M10_M11: coef_ff[2] <= csr_pwdata;
            REG_COEF_M12_M13: coef_ff[3] <= csr_pwdata;
            REG_COEF_M20_M21: coef_ff[4] <= csr_pwdata;
            REG_COEF_M22_M23: coef_ff[5] <= csr_pwdata;
            REG_CROP_LIMITS:  crop_ff    <= csr_pwdata;
            REG_FULL_DIST:    full_ff    <= csr_pwdata[15:0];
            default:          ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_COEF_M00_M01: csr_prdata = coef_ff[0];
         REG_COEF_M02_M03: csr_prdata = coef_ff[1];
         REG_COEF_M10_M11: csr_prdata = coef_ff[2];
         REG_COEF_M12_M13: csr_prdata = coef_ff[3];
         REG_COEF_M20_M21: csr_prdata = coef_ff[4];
         REG_COEF_M22_M23: csr_prdata = coef_ff[5];
         REG_CROP_LIMITS:  csr_prdata = crop_ff;
         REG_FULL_DIST:    csr_prdata = {48'd0, full_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // matrix entries, row r column c
   logic signed [COEF_W-1:0] mcoef [3][4];
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         mcoef[r][0] = coef_ff[2*r][31:0];
         mcoef[r][1] = coef_ff[2*r][63:32];
         mcoef[r][2] = coef_ff[2*r+1][31:0];
         mcoef[r][3] = coef_ff[2*r+1][63:32];
      end
   end

   // ---------------- pipeline enable ----------------
   logic rsp_valid_ff;
   logic en;
   logic accept;

   assign en        = !rsp_valid_ff || rsp.ready;
   assign req.ready = en;
   assign accept    = req.valid && en;

   // ---------------- crop test ----------------
   logic        [15:0] max_x, max_y, min_r;
   logic signed [15:0] min_z;
   logic        [16:0] abs_y;
   logic               keep;

   assign max_x = crop_ff[15:0];
   assign max_y = crop_ff[31:16];
   assign min_z = crop_ff[47:32];
   assign min_r = crop_ff[63:48];
   assign abs_y = req.point_y[15] ? 17'(-$signed({req.point_y[15], req.point_y}))
                                  : {1'b0, req.point_y};
   assign keep  = !req.point_x[15] && (req.point_x <= max_x) && (abs_y <= {1'b0, max_y})
               && (req.point_z >= min_z) && (req.reflectance >= min_r);

   // stage 1: captured point
   logic                      v1_ff;
   logic signed [COORD_W-1:0] pt1_ff [3];

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= accept && keep;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         pt1_ff[0] <= req.point_x;
         pt1_ff[1] <= req.point_y;
         pt1_ff[2] <= req.point_z;
      end
   end

   // stage 2: nine products and the translation terms
   logic                      v2_ff;
   logic signed [PROD_W-1:0]  prod_in [3][3];
   logic signed [PROD_W-1:0]  prod_ff [3][3];
   logic signed [BIAS_W-1:0]  bias_ff [3];
   logic signed [COORD_W-1:0] x2_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[r][c] = mcoef[r][c] * pt1_ff[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (en) v2_ff <= v1_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) prod_ff[r][c] <= prod_in[r][c];
            bias_ff[r] <= {mcoef[r][3], 8'd0};
         end
         x2_ff <= pt1_ff[0];
      end
   end

   // stage 3: row sums a, b, w
   logic                      v3_ff;
   logic signed [ROW_W-1:0]   row_in [3];
   logic signed [ROW_W-1:0]   row_ff [3];
   logic signed [COORD_W-1:0] x3_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         row_in[r] = prod_ff[r][0] + prod_ff[r][1] + prod_ff[r][2] + bias_ff[r];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (en) v3_ff <= v2_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) row_ff[r] <= row_in[r];
         x3_ff <= x2_ff;
      end
   end

   // stage 4: magnitudes, sign and behind flags, colour dividend
   logic        [ROW_W-1:0]     mag_a, mag_b, den_w;
   logic                        behind;
   logic        [15:0]          full_eff;
   logic signed [17:0]          diff;
   logic        [15:0]          dist_abs;
   logic        [ROW_W-1:0]     na_ff, nb_ff, dw_ff;
   logic        [COL_NUM_W-1:0] cnum_ff;
   logic        [COL_DEN_W-1:0] cden_ff;
   side_type                    side4_ff;

   assign behind   = row_ff[2][ROW_W-1] || (row_ff[2] == '0);
   assign mag_a    = row_ff[0][ROW_W-1] ? ROW_W'(-row_ff[0]) : ROW_W'(row_ff[0]);
   assign mag_b    = row_ff[1][ROW_W-1] ? ROW_W'(-row_ff[1]) : ROW_W'(row_ff[1]);
   // a non-positive w gets a dummy divisor of one, its quotients are discarded
   assign den_w    = behind ? ROW_W'(1) : ROW_W'(row_ff[2]);
   // zero full distance acts as one lsb
   assign full_eff = (full_ff == '0) ? 16'd1 : full_ff;
   assign diff     = 18'(x3_ff) - $signed({2'b00, full_eff});
   assign dist_abs = diff[17] ? 16'(-diff) : diff[15:0];

   always_ff @(posedge clock) begin
      if (reset) side4_ff.valid <= 1'b0;
      else if (en) side4_ff.valid <= v3_ff;
      if (en) begin
         side4_ff.behind <= behind;
         side4_ff.neg_a  <= row_ff[0][ROW_W-1];
         side4_ff.neg_b  <= row_ff[1][ROW_W-1];
         na_ff           <= mag_a;
         nb_ff           <= mag_b;
         dw_ff           <= den_w;
         cnum_ff         <= COL_NUM_W'(dist_abs) * COL_NUM_W'(255);
         cden_ff         <= full_eff;
      end
   end

   // dividers: u, v and colour share one latency
   logic [QUO_W-1:0]     qa, qb, qc;
   logic [ROW_W-1:0]     ra, rb, da, db;
   logic [COL_NUM_W-1:0] rc;
   logic [COL_DEN_W-1:0] dc;
   logic                 oa, ob, oc;

   lpp_div_pipe #(.NUM_W(ROW_W), .DEN_W(ROW_W), .QUO_W(QUO_W)) u_div_u (
      .clock(clock), .en(en), .num(na_ff), .den(dw_ff),
      .quo(qa), .rem(ra), .den_out(da), .ovf(oa));

   lpp_div_pipe #(.NUM_W(ROW_W), .DEN_W(ROW_W), .QUO_W(QUO_W)) u_div_v (
      .clock(clock), .en(en), .num(nb_ff), .den(dw_ff),
      .quo(qb), .rem(rb), .den_out(db), .ovf(ob));

   lpp_div_pipe #(.NUM_W(COL_NUM_W), .DEN_W(COL_DEN_W), .QUO_W(QUO_W)) u_div_col (
      .clock(clock), .en(en), .num(cnum_ff), .den(cden_ff),
      .quo(qc), .rem(rc), .den_out(dc), .ovf(oc));

   // flags ride alongside the divider stages
   side_type side_ff [QUO_W];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < QUO_W; k++) side_ff[k] <= '0;
      end else if (en) begin
         side_ff[0] <= side4_ff;
         for (int k = 1; k < QUO_W; k++) side_ff[k] <= side_ff[k-1];
      end
   end

   // round to nearest even and saturate to 16 bits signed
   function automatic logic [15:0] round_pixel(input logic [QUO_W-1:0] q,
                                               input logic [ROW_W-1:0] r,
                                               input logic [ROW_W-1:0] d,
                                               input logic             ovf,
                                               input logic             neg);
      logic [ROW_W:0]   r2;
      logic             up;
      logic [QUO_W:0]   qr;
      logic [15:0]      res;
      r2 = {r, 1'b0};
      up = (r2 > {1'b0, d}) || ((r2 == {1'b0, d}) && q[0]);
      qr = {1'b0, q} + (QUO_W+1)'(up);
      if (!neg) begin
         res = (ovf || (qr > (QUO_W+1)'(32767))) ? 16'h7FFF : qr[15:0];
      end else begin
         res = (ovf || (qr > (QUO_W+1)'(32768))) ? 16'h8000 : 16'(-qr[15:0]);
      end
      return res;
   endfunction

   side_type    side_out;
   logic [15:0] pu, pv;
   logic [7:0]  red, green;

   assign side_out = side_ff[QUO_W-1];
   assign pu = side_out.behind ? 16'd0 : round_pixel(qa, ra, da, oa, side_out.neg_a);
   assign pv = side_out.behind ? 16'd0 : round_pixel(qb, rb, db, ob, side_out.neg_b);
   // quotient below 255 exactly when dist < full; green is then 255 - ceil(255*dist/full)
   assign red   = (oc || (qc > QUO_W'(255))) ? 8'd255 : qc[7:0];
   assign green = (!oc && (qc < QUO_W'(255)))
                ? 8'(8'd255 - qc[7:0] - 8'((rc != '0) ? 1 : 0)) : 8'd0;

   // output register
   logic               behind_ff;
   logic signed [15:0] pu_ff, pv_ff;
   logic        [7:0]  red_ff, green_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (en) rsp_valid_ff <= side_out.valid;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         pu_ff     <= pu;
         pv_ff     <= pv;
         behind_ff <= side_out.behind;
         red_ff    <= red;
         green_ff  <= green;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.pixel_u       = pu_ff;
   assign rsp.pixel_v       = pv_ff;
   assign rsp.behind_camera = behind_ff;
   assign rsp.red_level     = red_ff;
   assign rsp.green_level   = green_ff;
   // unused lower address bits, register sits at 8*i
   logic unused_addr;
   assign unused_addr = ^csr_paddr[2:0] ^ ^dc;

endmodule
`default_nettype wire

/* src/lpp_div_pipe.sv */
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module lpp_div_pipe #(
   parameter int NUM_W = 50,
   parameter int DEN_W = 50,
   parameter int QUO_W = 17
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic      [QUO_W-1:0] quo,
   output logic      [NUM_W-1:0] rem,
   output logic      [DEN_W-1:0] den_out,
   output logic                  ovf
);
   localparam int CW = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;

   logic [NUM_W-1:0] rem_ff [QUO_W];
   logic [NUM_W-1:0] rem_in [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];
   logic [QUO_W-1:0] quo_in [QUO_W];
   logic             ovf_ff [QUO_W];

   always_comb begin
      logic [NUM_W-1:0] src_rem;
      logic [DEN_W-1:0] src_den;
      logic [QUO_W-1:0] src_quo;
      logic [CW-1:0]    trial;
      for (int k = 0; k < QUO_W; k++) begin
         src_rem = (k == 0) ? num : rem_ff[(k == 0) ? 0 : k-1];
         src_den = (k == 0) ? den : den_ff[(k == 0) ? 0 : k-1];
         src_quo = (k == 0) ? '0  : quo_ff[(k == 0) ? 0 : k-1];
         trial   = CW'(src_den) << (QUO_W - 1 - k);
         rem_in[k] = src_rem;
         quo_in[k] = src_quo;
         if (CW'(src_rem) >= trial) begin
            rem_in[k] = NUM_W'(CW'(src_rem) - trial);
            quo_in[k][QUO_W-1-k] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < QUO_W; k++) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
            den_ff[k] <= (k == 0) ? den : den_ff[(k == 0) ? 0 : k-1];
         end
         ovf_ff[0] <= CW'(num) >= (CW'(den) << QUO_W);
         for (int k = 1; k < QUO_W; k++) begin
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   assign quo     = quo_ff[QUO_W-1];
   assign rem     = rem_ff[QUO_W-1];
   assign den_out = den_ff[QUO_W-1];
   assign ovf     = ovf_ff[QUO_W-1];
endmodule
`default_nettype wire

/* src/lpp_checker.sv */
// port-level assertions for the projector core and their bind
`default_nettype none
module lpp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_pixel_u,
   input wire logic [15:0] rsp_pixel_v,
   input wire logic        rsp_behind
);
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   a_behind_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_behind) |-> (rsp_pixel_u == 16'd0 && rsp_pixel_v == 16'd0))
      else $error("behind camera with nonzero pixel");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_pixel_u)))
      else $error("stalled response changed");
endmodule

bind lidar_point_projector_core lpp_checker u_lpp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_pixel_u (rsp.pixel_u),
   .rsp_pixel_v (rsp.pixel_v),
   .rsp_behind  (rsp.behind_camera)
);
`default_nettype wire
